/* hw/rtl/qpe_pkg.sv */
`timescale 1ns / 1ps

package qpe_pkg;

    localparam logic [7:0] CHAR_LF          = 8'd10;
    localparam logic [7:0] CHAR_CR          = 8'd13;
    localparam logic [7:0] CHAR_EQ          = 8'd61;
    localparam logic [7:0] PRINT_LOW        = 8'd32;
    localparam logic [7:0] PRINT_HIGH       = 8'd126;
    localparam logic [7:0] LINE_LIMIT_RESET = 8'd75;

    localparam logic [1:0] BODY_LAST_PLAIN  = 2'd0;
    localparam logic [1:0] BODY_LAST_ESCAPE = 2'd2;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            brk_first;
    } char_seq_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] digit;
        if (nibble < 4'd10)
        begin
            digit = 8'd48 + {4'd0, nibble};
        end
        else
        begin
            digit = 8'd55 + {4'd0, nibble};
        end
        return digit;
    endfunction

endpackage

/* hw/rtl/qpe_channels.sv */
`timescale 1ns / 1ps

interface qpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       message_end;

    modport source (output valid, output in_byte, output message_end, input ready);
    modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface qpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       line_break_after;
    logic       run_last;
    logic       message_last;

    modport source (output valid, output out_char, output line_break_after,
                    output run_last, output message_last, input ready);
    modport sink   (input valid, input out_char, input line_break_after,
                    input run_last, input message_last, output ready);
endinterface

interface qpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/qpe_expand.sv */
`timescale 1ns / 1ps

module qpe_expand (
    input  logic [7:0]        in_byte,
    input  logic [7:0]        column_count,
    input  logic [7:0]        line_limit,
    output qpe_pkg::char_seq_t seq,
    output logic [7:0]        column_next
);

    logic            is_crlf;
    logic            is_escape;
    logic            brk;
    logic [2:0][7:0] body;
    logic [1:0]      body_last;

    assign is_crlf   = (in_byte == qpe_pkg::CHAR_LF) || (in_byte == qpe_pkg::CHAR_CR);
    assign is_escape = (in_byte < qpe_pkg::PRINT_LOW) || (in_byte == qpe_pkg::CHAR_EQ)
                       || (in_byte > qpe_pkg::PRINT_HIGH);
    assign brk       = (column_count >= line_limit) && !is_crlf;

    always_comb
    begin
        body      = '{default: 8'd0};
        body_last = qpe_pkg::BODY_LAST_PLAIN;
        if (!is_crlf && is_escape)
        begin
            body[0]   = qpe_pkg::CHAR_EQ;
            body[1]   = qpe_pkg::hex_digit(in_byte[7:4]);
            body[2]   = qpe_pkg::hex_digit(in_byte[3:0]);
            body_last = qpe_pkg::BODY_LAST_ESCAPE;
        end
        else
        begin
            body[0] = in_byte;
        end
    end

    // shift the body up by one place behind a soft break
    always_comb
    begin
        seq.brk_first = brk;
        if (brk)
        begin
            seq.chars    = {body[2], body[1], body[0], qpe_pkg::CHAR_EQ};
            seq.last_idx = body_last + 2'd1;
        end
        else
        begin
            seq.chars    = {8'd0, body[2], body[1], body[0]};
            seq.last_idx = body_last;
        end
    end

    always_comb
    begin
        if (is_crlf)
        begin
            column_next = 8'd0;
        end
        else if (brk)
        begin
            column_next = 8'd1;
        end
        else
        begin
            column_next = column_count + 8'd1;
        end
    end

endmodule

/* hw/rtl/quoted_printable_encoder_unit.sv */
`timescale 1ns / 1ps

// Quoted-printable encoder. Each accepted byte becomes one to four output
// characters, sent one a cycle while the receiver is ready from a single
// sequence register: one for a plain byte, CR or LF, three for an escaped
// byte (=XX), and one more when a soft line break '=' goes in front. A
// one-word input register takes the next byte while the current sequence
// drains, so bytes that expand to one character stream at one per cycle
// while the receiver is ready. The line limit is written on the always-ready
// configuration channel and takes effect from the next byte expanded.
module quoted_printable_encoder_unit (
    input  logic             clk,
    input  logic             rst_n,
    qpe_in_if.sink           in_ch,
    qpe_out_if.source        out_ch,
    qpe_cfg_if.sink          cfg
);

    logic               hold_valid_reg;
    logic [7:0]         hold_byte_reg;
    logic               hold_end_reg;

    logic               seq_valid_reg;
    qpe_pkg::char_seq_t seq_reg;
    logic [1:0]         idx_reg;
    logic               seq_end_reg;

    logic [7:0]         line_limit_reg;
    logic [7:0]         column_reg;

    qpe_pkg::char_seq_t exp_seq;
    logic [7:0]         column_next;

    logic               in_fire;
    logic               out_fire;
    logic               at_last;
    logic               seq_free;
    logic               load;

    qpe_expand u_expand (
        .in_byte      (hold_byte_reg),
        .column_count (column_reg),
        .line_limit   (line_limit_reg),
        .seq          (exp_seq),
        .column_next  (column_next)
    );

    assign at_last  = (idx_reg == seq_reg.last_idx);
    assign out_fire = seq_valid_reg && out_ch.ready;
    assign seq_free = !seq_valid_reg || (out_fire && at_last);
    assign load     = hold_valid_reg && seq_free;
    assign in_fire  = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !hold_valid_reg || load;
    assign cfg.ready   = 1'b1;

    assign out_ch.valid            = seq_valid_reg;
    assign out_ch.out_char         = seq_reg.chars[idx_reg];
    assign out_ch.line_break_after = seq_reg.brk_first && (idx_reg == 2'd0);
    assign out_ch.run_last         = at_last;
    assign out_ch.message_last     = at_last && seq_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= qpe_pkg::LINE_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            line_limit_reg <= cfg.data;
        end
    end

    // hold the incoming word until the output side is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_byte_reg <= in_ch.in_byte;
            hold_end_reg  <= in_ch.message_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            column_reg    <= 8'd0;
        end
        else if (load)
        begin
            seq_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
            column_reg    <= column_next;
        end
        else if (out_fire)
        begin
            if (at_last)
            begin
                seq_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg     <= exp_seq;
            seq_end_reg <= hold_end_reg;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid_reg |-> (idx_reg <= seq_reg.last_idx))
        else $error("character index past end of sequence");

    a_msg_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.message_last) |-> out_ch.run_last)
        else $error("message end flagged before last character of a byte");

    a_crlf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && ((hold_byte_reg == qpe_pkg::CHAR_CR) || (hold_byte_reg == qpe_pkg::CHAR_LF)))
        |=> (column_reg == 8'd0))
        else $error("column not cleared after CR or LF");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !seq_free) |=> hold_valid_reg)
        else $error("held word dropped while output busy");

endmodule

/* tb/quoted_printable_encoder_unit_tb.sv */
`timescale 1ns / 1ps

typedef struct {
    logic [7:0] ch;
    logic       brk;
    logic       run_last;
    logic       msg_last;
} qp_char_t;

class qp_encode_scoreboard;
    logic [7:0] line_limit;
    logic [7:0] column_count;
    qp_char_t   expected_chars[$];
    int         mismatches;
    int         chars_checked;
    int         bytes_noted;
    int         messages;
    int         soft_breaks;
    int         escapes;
    int         limits_written;

    function new();
        line_limit     = qpe_pkg::LINE_LIMIT_RESET;
        column_count   = 8'd0;
        mismatches     = 0;
        chars_checked  = 0;
        bytes_noted    = 0;
        messages       = 0;
        soft_breaks    = 0;
        escapes        = 0;
        limits_written = 0;
    endfunction

    function logic [7:0] ascii_hex(input logic [3:0] nib);
        logic [7:0] digit;
        if (nib > 4'd9)
        begin
            digit = "A" + 8'(nib - 4'd10);
        end
        else
        begin
            digit = "0" + 8'(nib);
        end
        return digit;
    endfunction

    function qp_char_t make_char(input logic [7:0] ch, input logic brk);
        qp_char_t c;
        c.ch       = ch;
        c.brk      = brk;
        c.run_last = 1'b0;
        c.msg_last = 1'b0;
        return c;
    endfunction

    function void note_byte(input logic [7:0] b, input logic msg_end);
        qp_char_t run[$];
        qp_char_t tail;
        logic     is_crlf;
        is_crlf = (b == qpe_pkg::CHAR_CR) || (b == qpe_pkg::CHAR_LF);
        bytes_noted++;
        if (msg_end)
        begin
            messages++;
        end
        if (column_count >= line_limit && !is_crlf)
        begin
            run.insert(run.size(), make_char(qpe_pkg::CHAR_EQ, 1'b1));
            column_count = 8'd0;
            soft_breaks++;
        end
        if (is_crlf)
        begin
            run.insert(run.size(), make_char(b, 1'b0));
            column_count = 8'd0;
        end
        else if (b < qpe_pkg::PRINT_LOW || b == qpe_pkg::CHAR_EQ || b > qpe_pkg::PRINT_HIGH)
        begin
            run.insert(run.size(), make_char(qpe_pkg::CHAR_EQ, 1'b0));
            run.insert(run.size(), make_char(ascii_hex(b[7:4]), 1'b0));
            run.insert(run.size(), make_char(ascii_hex(b[3:0]), 1'b0));
            column_count = column_count + 8'd1;
            escapes++;
        end
        else
        begin
            run.insert(run.size(), make_char(b, 1'b0));
            column_count = column_count + 8'd1;
        end
        tail = run[run.size() - 1];
        tail.run_last = 1'b1;
        tail.msg_last = msg_end;
        run[run.size() - 1] = tail;
        foreach (run[i])
        begin
            expected_chars.insert(expected_chars.size(), run[i]);
        end
    endfunction

    task report(input string what);
        if (mismatches < 40)
        begin
            $display("%0t mismatch: %s", $realtime, what);
        end
        mismatches++;
    endtask

    task check_char(input logic [7:0] ch, input logic brk, input logic rl, input logic ml);
        qp_char_t want;
        chars_checked++;
        if (expected_chars.size() == 0)
        begin
            report($sformatf("character %h arrived with nothing outstanding", ch));
        end
        else
        begin
            want = expected_chars.pop_front();
            if (ch !== want.ch)
            begin
                report($sformatf("out_char %h, wanted %h", ch, want.ch));
            end
            if (brk !== want.brk)
            begin
                report($sformatf("line_break_after %b, wanted %b", brk, want.brk));
            end
            if (rl !== want.run_last)
            begin
                report($sformatf("run_last %b, wanted %b", rl, want.run_last));
            end
            if (ml !== want.msg_last)
            begin
                report($sformatf("message_last %b, wanted %b", ml, want.msg_last));
            end
        end
    endtask
endclass

module quoted_printable_encoder_unit_tb;

    logic clk;
    logic rst_n;

    qpe_in_if  in_if();
    qpe_out_if out_if();
    qpe_cfg_if cfg_if();

    qp_encode_scoreboard sb = new();

    int hold_requests;
    int hold_served;
    int hold_left;
    int rx_cycle;

    quoted_printable_encoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: long hold on request, otherwise a stall pattern that shifts with rx_cycle[7:6]
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            out_if.ready <= 1'b0;
            hold_served  <= hold_served + 1;
            hold_left    <= 200;
        end
        else
        begin
            case (rx_cycle[7:6])
                2'd0: out_if.ready <= 1'b1;
                2'd1: out_if.ready <= ($urandom_range(0, 1) == 0);
                2'd2: out_if.ready <= (rx_cycle[1:0] == 2'd0);
                default: out_if.ready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            sb.check_char(out_if.out_char, out_if.line_break_after,
                          out_if.run_last, out_if.message_last);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_if.valid       <= 1'b1;
        in_if.in_byte     <= b;
        in_if.message_end <= fin;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        sb.note_byte(b, fin);
    endtask

    task automatic wait_drained();
        while (sb.expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        sb.line_limit = v;
        sb.limits_written++;
    endtask

    task automatic send_run(input logic [7:0] seq[$]);
        foreach (seq[i])
        begin
            send_byte(seq[i], i == seq.size() - 1);
        end
        in_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: b = 8'($urandom_range(33, 126));
            5:       b = " ";
            6:       b = qpe_pkg::CHAR_CR;
            7:       b = 8'($urandom_range(0, 31));
            8:       b = 8'($urandom_range(127, 255));
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    task automatic run_phase(input int n, input bit gappy, input bit hold, input int drain_at);
        int         burst;
        int         gap;
        logic [7:0] b;
        logic       fin;
        bit         lf_next;
        burst   = 0;
        lf_next = 1'b0;
        if (hold)
        begin
            hold_requests++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == drain_at)
            begin
                in_if.valid <= 1'b0;
                wait_drained();
            end
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                gap   = gappy ? $urandom_range(0, 5) : 0;
                if (gap > 0)
                begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            // follow a CR with LF to close the line
            b       = lf_next ? qpe_pkg::CHAR_LF : pick_byte();
            lf_next = (b == qpe_pkg::CHAR_CR);
            fin     = ($urandom_range(0, 19) == 0);
            send_byte(b, fin);
            burst--;
        end
        in_if.valid <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'd0;
        in_if.message_end = 1'b0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = 8'd0;
        hold_requests     = 0;
        hold_served       = 0;
        hold_left         = 0;
        rx_cycle          = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_run('{8'h00, 8'hFF, "A", " ", qpe_pkg::CHAR_EQ, qpe_pkg::CHAR_CR,
                   qpe_pkg::CHAR_LF, qpe_pkg::PRINT_HIGH, 8'h7F, 8'h1F, 8'h80, 8'hE9});
        write_limit(8'd1);
        send_run('{"a", "b", qpe_pkg::CHAR_EQ, qpe_pkg::CHAR_CR, "c"});
        write_limit(8'd0);
        send_run('{"x", qpe_pkg::CHAR_LF, 8'h00});
        write_limit(8'd255);
        send_run('{"p", "p", "p", "p"});
        // drop the limit below the current column
        write_limit(8'd2);
        send_run('{"z", "y"});

        write_limit(qpe_pkg::LINE_LIMIT_RESET);
        run_phase(60, 1'b1, 1'b0, 30);
        write_limit(8'd1);
        run_phase(30, 1'b0, 1'b0, -1);
        write_limit(8'd255);
        run_phase(40, 1'b0, 1'b1, -1);
        write_limit(8'($urandom_range(2, 20)));
        run_phase(40, 1'b1, 1'b0, -1);
        write_limit(8'd0);
        run_phase(25, 1'b1, 1'b0, -1);
        write_limit(8'($urandom_range(1, 255)));
        run_phase(40, 1'b1, 1'b0, -1);
        write_limit(8'd10);
        run_phase(50, 1'b0, 1'b0, -1);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d bytes in %0d messages over %0d line limit writes,",
                 sb.bytes_noted, sb.messages, sb.limits_written);
        $display("0 and 255 included; checked %0d characters: %0d soft breaks, %0d escapes.",
                 sb.chars_checked, sb.soft_breaks, sb.escapes);
        if (sb.mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
